// File: hdl/pidaw_pkg.sv
// Shared constants, codes and handshake structs for the PID regulator.
`timescale 1ns / 1ps

package pidaw_pkg;

    // Fixed-point formats
    localparam int FRAC_BITS = 16;
    localparam int GAIN_W    = 16;
    localparam int GAIN_FRAC = 8;

    // Field widths
    localparam int KIND_W    = 2;
    localparam int IN_W      = 31;
    localparam int LT_W      = 16;
    localparam int DRIVE_W   = 25;
    localparam int CFG_IDX_W = 2;

    // State widths
    localparam int ERR_W = 32;
    localparam int SUM_W = 48;

    // Serial multiplier: wide multiplicand times a 16-bit gain or loop time
    localparam int MC_W   = 48;
    localparam int MP_W   = 16;
    localparam int PROD_W = MC_W + MP_W;

    // Serial divider: |sum| * lt (below 2^63) scaled by 256, over 1000 * Ti
    localparam int DIVD_W = PROD_W - 1 + GAIN_FRAC;
    localparam int DIVS_W = 26;

    // Register reset values
    localparam logic [GAIN_W-1:0] P_RESET  = 16'd512;
    localparam logic [GAIN_W-1:0] TI_RESET = 16'd5120;
    localparam logic [GAIN_W-1:0] D_RESET  = 16'd0;

    // Item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_BIASED = 2'd0,
        KIND_SIGNED = 2'd1,
        KIND_SKIP   = 2'd2
    } kind_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_P_GAIN = 2'd0,
        REG_TI     = 2'd1,
        REG_D_GAIN = 2'd2
    } cfg_reg_t;

    // Multiplier request
    typedef struct packed {
        logic              start;
        logic [MC_W-1:0]   mcand;
        logic [MP_W-1:0]   mplier;
    } mul_req_t;

    // Divider request
    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;

endpackage

// File: hdl/pidaw_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps

module pidaw_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pidaw_pkg::mul_req_t           req,
    output logic                          done,
    output logic [pidaw_pkg::PROD_W-1:0]  prod
);

    localparam int CNT_W = $clog2(pidaw_pkg::MP_W);

    logic                          busy_reg;
    logic                          done_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [pidaw_pkg::MC_W-1:0]    mc_reg;
    logic [pidaw_pkg::PROD_W-1:0]  prod_reg;
    logic [pidaw_pkg::MC_W:0]      part_next;

    // Add the multiplicand into the upper half when the low bit is set
    assign part_next = {1'b0, prod_reg[pidaw_pkg::PROD_W-1:pidaw_pkg::MP_W]}
                     + (prod_reg[0] ? {1'b0, mc_reg} : {(pidaw_pkg::MC_W + 1){1'b0}});

    // Sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(pidaw_pkg::MP_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift register: partial product above, remaining multiplier bits below
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            mc_reg   <= req.mcand;
            prod_reg <= {{pidaw_pkg::MC_W{1'b0}}, req.mplier};
        end
        else if (busy_reg)
        begin
            prod_reg <= {part_next, prod_reg[pidaw_pkg::MP_W-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

// File: hdl/pidaw_div.sv
// Restoring bit-serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module pidaw_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pidaw_pkg::div_req_t           req,
    output logic                          done,
    output logic [pidaw_pkg::DIVD_W-1:0]  quo
);

    localparam int CNT_W = $clog2(pidaw_pkg::DIVD_W);

    logic                          busy_reg;
    logic                          done_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [pidaw_pkg::DIVS_W-1:0]  rem_reg;
    logic [pidaw_pkg::DIVS_W-1:0]  dvs_reg;
    logic [pidaw_pkg::DIVD_W-1:0]  quo_reg;
    logic [pidaw_pkg::DIVS_W:0]    trial;
    logic [pidaw_pkg::DIVS_W:0]    diff;
    logic                          fits;

    // Bring down the next dividend bit and try the subtraction
    assign trial = {rem_reg, quo_reg[pidaw_pkg::DIVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    // Sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(pidaw_pkg::DIVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift registers
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            dvs_reg <= req.divisor;
            quo_reg <= req.dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[pidaw_pkg::DIVS_W-1:0] : trial[pidaw_pkg::DIVS_W-1:0];
            quo_reg <= {quo_reg[pidaw_pkg::DIVD_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// File: hdl/pid_regulator_antiwindup.sv
// PID regulator with anti-windup: sequencer, state and output stage.
//
// Usage: an input item (kind, setpoint, measured, loop_time_ms) is taken when
// in_valid and in_ready are both high; in_ready is high only while no item is
// in work. Kinds biased and signed produce one result item (drive, saturated)
// on the out_valid/out_ready channel; a skip item and the unused kind produce
// none. Gains are written through cfg_valid/cfg_ready/cfg_index/cfg_data
// (0 P gain, 1 integral time, 2 D gain); cfg_ready is always high and writes
// belong in idle periods.
// The time from acceptance to result is set by the shared bit-serial
// multiplier (up to three products) and the 71-step restoring divider of the
// integral term; the integral product and divider run only with integral
// action on, the derivative product only with derivative action on. A skip
// item returns to idle from the error state. One item is in work at a time.
// Reset clears the error sum and the last error, loads the gain reset values
// and empties the output register. A stalled receiver holds the result in the
// output register while the next item is taken and worked; that item waits in
// its final state until the register frees.
`timescale 1ns / 1ps

module pid_regulator_antiwindup (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // input channel
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [pidaw_pkg::KIND_W-1:0]           kind,
    input  logic signed [pidaw_pkg::IN_W-1:0]      setpoint,
    input  logic signed [pidaw_pkg::IN_W-1:0]      measured,
    input  logic [pidaw_pkg::LT_W-1:0]             loop_time_ms,
    // result channel
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [pidaw_pkg::DRIVE_W-1:0]   drive,
    output logic                                   saturated,
    // configuration channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [pidaw_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pidaw_pkg::GAIN_W-1:0]           cfg_data
);

    localparam int ERR_W   = pidaw_pkg::ERR_W;
    localparam int SUM_W   = pidaw_pkg::SUM_W;
    localparam int IN_W    = pidaw_pkg::IN_W;
    localparam int MC_W    = pidaw_pkg::MC_W;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int IQ_BIT  = 42;
    localparam int ITERM_W = IQ_BIT + 2;
    localparam int DTERM_W = 41;
    localparam int TERM_W  = 45;
    localparam int TMAG_W  = 41;
    localparam int U_W     = 50;
    localparam int GF      = pidaw_pkg::GAIN_FRAC;
    localparam int TI_SCALE = 1000;

    localparam logic signed [TERM_W-1:0] TERM_LIM = 45'sh100_0000_0000;
    localparam logic signed [TERM_W-1:0] TERM_NEG = -TERM_LIM;
    localparam logic signed [U_W-1:0] BIAS = U_W'(64'(100) << pidaw_pkg::FRAC_BITS);
    localparam logic signed [U_W-1:0] HI_B = U_W'(64'(200) << pidaw_pkg::FRAC_BITS);
    localparam logic signed [U_W-1:0] LO_B = '0;
    localparam logic signed [U_W-1:0] HI_S = U_W'(64'(30) << pidaw_pkg::FRAC_BITS);
    localparam logic signed [U_W-1:0] LO_S = -HI_S;
    localparam logic [U_W-1:0] FRAC_MASK = U_W'((64'(1) << pidaw_pkg::FRAC_BITS) - 64'(1));

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_SUM,
        S_ISTART,
        S_IMUL,
        S_IDIV,
        S_DSTART,
        S_DMUL,
        S_TOTAL,
        S_PSTART,
        S_PMUL,
        S_CLAMP,
        S_OUT
    } state_t;

    // Saturate a one-bit-wider sum into the error sum range
    function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] a);
        logic signed [SUM_W-1:0] r;
        if (a[SUM_W] != a[SUM_W-1])
            r = a[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}} : {1'b0, {(SUM_W - 1){1'b1}}};
        else
            r = a[SUM_W-1:0];
        return r;
    endfunction

    state_t                              state_reg;
    logic [pidaw_pkg::GAIN_W-1:0]        p_gain_reg;
    logic [pidaw_pkg::GAIN_W-1:0]        ti_reg;
    logic [pidaw_pkg::GAIN_W-1:0]        d_gain_reg;
    logic signed [SUM_W-1:0]             sum_reg;
    logic signed [ERR_W-1:0]             prev_reg;
    logic                                out_valid_reg;
    logic signed [pidaw_pkg::DRIVE_W-1:0] drive_reg;
    logic                                sat_reg;

    // item working registers
    logic [pidaw_pkg::KIND_W-1:0]        kind_reg;
    logic signed [IN_W-1:0]              sp_reg;
    logic signed [IN_W-1:0]              meas_reg;
    logic [pidaw_pkg::LT_W-1:0]          lt_reg;
    logic signed [ERR_W-1:0]             err_reg;
    logic signed [ITERM_W-1:0]           iterm_reg;
    logic signed [DTERM_W-1:0]           dterm_reg;
    logic                                dneg_reg;
    logic                                tneg_reg;
    logic [TMAG_W-1:0]                   tmag_reg;
    logic signed [U_W-1:0]               u_reg;
    logic signed [pidaw_pkg::DRIVE_W-1:0] res_drive_reg;
    logic                                res_sat_reg;

    logic                                ti_on;
    logic                                d_on;
    logic signed [ERR_W-1:0]             err_w;
    logic signed [SUM_W:0]               sum_x;
    logic signed [SUM_W:0]               err_x;
    logic signed [SUM_W:0]               prev_x;
    logic signed [SUM_W-1:0]             sum_plus_err;
    logic signed [SUM_W-1:0]             sum_minus_err;
    logic signed [SUM_W-1:0]             sum_minus_prev;
    logic [SUM_W-1:0]                    sum_mag;
    logic signed [DIFF_W-1:0]            diff_w;
    logic [DIFF_W-1:0]                   diff_mag;
    logic [IQ_BIT:0]                     iq_mag;
    logic signed [ITERM_W-1:0]           iterm_w;
    logic [DTERM_W-2:0]                  dmag_w;
    logic signed [DTERM_W-1:0]           dterm_w;
    logic signed [TERM_W-1:0]            total_w;
    logic signed [TERM_W-1:0]            total_c;
    logic [TERM_W-1:0]                   tabs_w;
    logic [U_W-2:0]                      umag_w;
    logic signed [U_W-1:0]               u_w;
    logic signed [U_W-1:0]               v_w;
    logic signed [U_W-1:0]               lo_w;
    logic signed [U_W-1:0]               hi_w;
    logic signed [U_W-1:0]               clamp_w;
    logic signed [U_W-1:0]               drive_w;
    logic                                sat_w;

    pidaw_pkg::mul_req_t                 mul_req;
    logic                                mul_done;
    logic [pidaw_pkg::PROD_W-1:0]        mul_prod;
    pidaw_pkg::div_req_t                 div_req;
    logic                                div_done;
    logic [pidaw_pkg::DIVD_W-1:0]        div_quo;

    assign ti_on = (ti_reg != '0);
    assign d_on  = (d_gain_reg != '0);

    // Error and error sum arithmetic
    assign err_w  = {sp_reg[IN_W-1], sp_reg} - {meas_reg[IN_W-1], meas_reg};
    assign sum_x  = {sum_reg[SUM_W-1], sum_reg};
    assign err_x  = {{(SUM_W + 1 - ERR_W){err_reg[ERR_W-1]}}, err_reg};
    assign prev_x = {{(SUM_W + 1 - ERR_W){prev_reg[ERR_W-1]}}, prev_reg};
    assign sum_plus_err   = sat_sum(sum_x + err_x);
    assign sum_minus_err  = sat_sum(sum_x - err_x);
    assign sum_minus_prev = sat_sum(sum_x - prev_x);
    assign sum_mag = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;

    // Derivative difference uses the last error before it is replaced
    assign diff_w   = {prev_reg[ERR_W-1], prev_reg} - {err_reg[ERR_W-1], err_reg};
    assign diff_mag = diff_w[DIFF_W-1] ? (~diff_w + 1'b1) : diff_w;

    // Integral term: quotient limited to 2^42, far past the term clamp
    assign iq_mag  = (|div_quo[pidaw_pkg::DIVD_W-1:IQ_BIT])
                   ? {1'b1, {IQ_BIT{1'b0}}} : div_quo[IQ_BIT:0];
    assign iterm_w = sum_reg[SUM_W-1] ? -{1'b0, iq_mag} : {1'b0, iq_mag};

    // Derivative term
    assign dmag_w  = mul_prod[GF+DTERM_W-2:GF];
    assign dterm_w = dneg_reg ? -{1'b0, dmag_w} : {1'b0, dmag_w};

    // Term sum, clamped to +-2^40
    assign total_w = {{(TERM_W - ERR_W){err_reg[ERR_W-1]}}, err_reg}
                   + {{(TERM_W - ITERM_W){iterm_reg[ITERM_W-1]}}, iterm_reg}
                   + {{(TERM_W - DTERM_W){dterm_reg[DTERM_W-1]}}, dterm_reg};

    always_comb
    begin
        priority if (total_w > TERM_LIM)
            total_c = TERM_LIM;
        else if (total_w < TERM_NEG)
            total_c = TERM_NEG;
        else
            total_c = total_w;
    end

    assign tabs_w = total_c[TERM_W-1] ? (~total_c + 1'b1) : total_c;

    // Proportional scaling
    assign umag_w = mul_prod[GF+U_W-2:GF];
    assign u_w    = tneg_reg ? -{1'b0, umag_w} : {1'b0, umag_w};

    // Bias, clamp and saturation flag
    always_comb
    begin
        if (kind_reg == pidaw_pkg::KIND_BIASED)
        begin
            v_w  = u_reg + BIAS;
            lo_w = LO_B;
            hi_w = HI_B;
        end
        else
        begin
            v_w  = u_reg;
            lo_w = LO_S;
            hi_w = HI_S;
        end
        priority if (v_w > hi_w)
            clamp_w = hi_w;
        else if (v_w < lo_w)
            clamp_w = lo_w;
        else
            clamp_w = v_w;
        sat_w = (clamp_w == lo_w) || (clamp_w == hi_w);
        if (kind_reg == pidaw_pkg::KIND_BIASED)
            drive_w = $signed(clamp_w & ~FRAC_MASK);
        else
            drive_w = clamp_w;
    end

    // Shared multiplier operand select
    always_comb
    begin
        mul_req = '0;
        unique case (state_reg)
            S_ISTART:
            begin
                mul_req.start  = 1'b1;
                mul_req.mcand  = sum_mag;
                mul_req.mplier = lt_reg;
            end
            S_DSTART:
            begin
                mul_req.start  = d_on;
                mul_req.mcand  = MC_W'(diff_mag);
                mul_req.mplier = d_gain_reg;
            end
            S_PSTART:
            begin
                mul_req.start  = 1'b1;
                mul_req.mcand  = MC_W'(tmag_reg);
                mul_req.mplier = p_gain_reg;
            end
            default:
            begin
                mul_req = '0;
            end
        endcase
    end

    // Divider launch right after the integral product
    assign div_req.start    = (state_reg == S_IMUL) && mul_done;
    assign div_req.dividend = {mul_prod[pidaw_pkg::PROD_W-2:0], {GF{1'b0}}};
    assign div_req.divisor  = pidaw_pkg::DIVS_W'(32'(ti_reg) * 32'(TI_SCALE));

    pidaw_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    pidaw_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Sequencer, regulator state, gains and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            p_gain_reg    <= pidaw_pkg::P_RESET;
            ti_reg        <= pidaw_pkg::TI_RESET;
            d_gain_reg    <= pidaw_pkg::D_RESET;
            sum_reg       <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
            drive_reg     <= '0;
            sat_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    pidaw_pkg::REG_P_GAIN: p_gain_reg <= cfg_data;
                    pidaw_pkg::REG_TI:     ti_reg     <= cfg_data;
                    pidaw_pkg::REG_D_GAIN: d_gain_reg <= cfg_data;
                    default:               ;
                endcase
            end

            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                        state_reg <= S_ERR;
                end
                S_ERR:
                begin
                    unique case (kind_reg)
                        pidaw_pkg::KIND_BIASED,
                        pidaw_pkg::KIND_SIGNED:
                        begin
                            state_reg <= S_SUM;
                        end
                        pidaw_pkg::KIND_SKIP:
                        begin
                            if (ti_on)
                                sum_reg <= sum_minus_prev;
                            state_reg <= S_IDLE;
                        end
                        default:
                        begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_SUM:
                begin
                    if (ti_on)
                    begin
                        sum_reg   <= sum_plus_err;
                        state_reg <= S_ISTART;
                    end
                    else
                    begin
                        state_reg <= S_DSTART;
                    end
                end
                S_ISTART:
                begin
                    state_reg <= S_IMUL;
                end
                S_IMUL:
                begin
                    if (mul_done)
                        state_reg <= S_IDIV;
                end
                S_IDIV:
                begin
                    if (div_done)
                        state_reg <= S_DSTART;
                end
                S_DSTART:
                begin
                    if (kind_reg == pidaw_pkg::KIND_SIGNED || d_on)
                        prev_reg <= err_reg;
                    state_reg <= d_on ? S_DMUL : S_TOTAL;
                end
                S_DMUL:
                begin
                    if (mul_done)
                        state_reg <= S_TOTAL;
                end
                S_TOTAL:
                begin
                    state_reg <= S_PSTART;
                end
                S_PSTART:
                begin
                    state_reg <= S_PMUL;
                end
                S_PMUL:
                begin
                    if (mul_done)
                        state_reg <= S_CLAMP;
                end
                S_CLAMP:
                begin
                    // anti-windup: back this error out of the sum at a limit
                    if (ti_on && sat_w)
                        sum_reg <= sum_minus_err;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        drive_reg     <= res_drive_reg;
                        sat_reg       <= res_sat_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Item datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_reg <= kind;
                    sp_reg   <= setpoint;
                    meas_reg <= measured;
                    lt_reg   <= loop_time_ms;
                end
            end
            S_ERR:
            begin
                err_reg   <= err_w;
                iterm_reg <= '0;
                dterm_reg <= '0;
            end
            S_IDIV:
            begin
                if (div_done)
                    iterm_reg <= iterm_w;
            end
            S_DSTART:
            begin
                dneg_reg <= diff_w[DIFF_W-1];
            end
            S_DMUL:
            begin
                if (mul_done)
                    dterm_reg <= dterm_w;
            end
            S_TOTAL:
            begin
                tneg_reg <= total_c[TERM_W-1];
                tmag_reg <= tabs_w[TMAG_W-1:0];
            end
            S_PMUL:
            begin
                if (mul_done)
                    u_reg <= u_w;
            end
            S_CLAMP:
            begin
                res_drive_reg <= drive_w[pidaw_pkg::DRIVE_W-1:0];
                res_sat_reg   <= sat_w;
            end
            default:
            begin
            end
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign saturated = sat_reg;

    // One item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while an item is in work");

    // Multiplier results only arrive while the sequencer waits for them
    a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == S_IMUL || state_reg == S_DMUL || state_reg == S_PMUL))
        else $error("multiplier finished outside a wait state");

    // Divider result only arrives in the integral wait
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_IDIV))
        else $error("divider finished outside the integral wait");

    // A saturated result sits on one of the clamp limits
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |->
            (drive == pidaw_pkg::DRIVE_W'(LO_B) || drive == pidaw_pkg::DRIVE_W'(HI_B)
             || drive == pidaw_pkg::DRIVE_W'(LO_S) || drive == pidaw_pkg::DRIVE_W'(HI_S)))
        else $error("saturated flag without a clamp limit on drive");

endmodule

// File: tb/sv/pid_regulator_antiwindup_tb.sv
// Testbench for the PID regulator: directed and random items checked against an in-bench predictor.
`timescale 1ns / 1ps

module pid_regulator_antiwindup_tb;

    import pidaw_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 160;        // longer than the worst item latency
    localparam int HOLD_CYCLES   = 500;        // receiver hold-off for the pressure test
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int MAX_REPORTS   = 30;
    localparam int PHASES        = 13;
    localparam int PHASE_ITEMS   = 146;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam int ONE = 1 << FRAC_BITS;
    localparam logic signed [IN_W-1:0] IN_MAX = {1'b0, {(IN_W-1){1'b1}}};
    localparam logic signed [IN_W-1:0] IN_MIN = {1'b1, {(IN_W-1){1'b0}}};

    localparam longint SUM_HI     = (longint'(1) <<< (SUM_W - 1)) - 1;
    localparam longint SUM_LO     = -SUM_HI - 1;
    localparam longint TERM_CAP   = longint'(1) <<< 40;
    localparam longint BIAS       = longint'(100) <<< FRAC_BITS;
    localparam longint BIASED_TOP = longint'(200) <<< FRAC_BITS;
    localparam longint SIGNED_TOP = longint'(30) <<< FRAC_BITS;

    // DUT ports
    logic                        clk          = 1'b0;
    logic                        rst_n        = 1'b0;
    logic                        in_valid     = 1'b0;
    logic                        in_ready;
    logic [KIND_W-1:0]           kind         = '0;
    logic signed [IN_W-1:0]      setpoint     = '0;
    logic signed [IN_W-1:0]      measured     = '0;
    logic [LT_W-1:0]             loop_time_ms = '0;
    logic                        out_valid;
    logic                        out_ready    = 1'b0;
    logic signed [DRIVE_W-1:0]   drive;
    logic                        saturated;
    logic                        cfg_valid    = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index    = '0;
    logic [GAIN_W-1:0]           cfg_data     = '0;

    // expected result of one item
    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      saturated;
    } drive_result_t;

    drive_result_t drive_q[$];

    // predictor state and gains
    logic [GAIN_W-1:0] p_gain_m  = P_RESET;
    logic [GAIN_W-1:0] ti_m      = TI_RESET;
    logic [GAIN_W-1:0] d_gain_m  = D_RESET;
    longint            err_sum_m = 0;
    longint            last_err_m = 0;

    // run control and bookkeeping
    bit  sender_idles  = 1'b1;
    bit  sink_idles    = 1'b1;
    bit  hold_request  = 1'b0;
    int  fail_count    = 0;
    int  results_seen  = 0;
    int  clamp_hits    = 0;
    int  items_sent    = 0;
    int  gain_settings = 0;
    int  skip_fill     = 0;
    int  cycle_count   = 0;

    pid_regulator_antiwindup i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .setpoint     (setpoint),
        .measured     (measured),
        .loop_time_ms (loop_time_ms),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .drive        (drive),
        .saturated    (saturated),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // ---------------------------------------------------------------- predictor

    function automatic logic [63:0] magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint clip_sum(longint v);
        if (v > SUM_HI) return SUM_HI;
        if (v < SUM_LO) return SUM_LO;
        return v;
    endfunction

    // v * g in Q8.8, truncated toward zero
    function automatic longint scale_q88(longint v, logic [GAIN_W-1:0] g);
        logic [63:0] m;
        m = (magnitude(v) * g) >> GAIN_FRAC;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    // lt * sum * 256 / (1000 * Ti), truncated toward zero
    function automatic longint integral_part(longint s, logic [LT_W-1:0] lt,
                                             logic [GAIN_W-1:0] ti);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] quo;
        logic [63:0] rem;
        num = magnitude(s) * lt;
        den = 64'd1000 * ti;
        quo = num / den;
        rem = num % den;
        quo = quo * 64'd256 + (rem * 64'd256) / den;
        return (s < 0) ? -longint'(quo) : longint'(quo);
    endfunction

    // advance the regulator state by one item and queue the result it yields
    function automatic void regulate_item(logic [KIND_W-1:0] k, logic signed [IN_W-1:0] sp,
                                          logic signed [IN_W-1:0] y, logic [LT_W-1:0] lt);
        longint        err;
        longint        iterm = 0;
        longint        dterm = 0;
        longint        total;
        longint        u;
        longint        lo;
        longint        hi;
        logic          sat;
        drive_result_t res;
        if (k == KIND_SKIP) begin
            if (ti_m != 0)
                err_sum_m = clip_sum(err_sum_m - last_err_m);
            return;
        end
        if (k == KIND_UNUSED)
            return;

        err = longint'(sp) - longint'(y);
        if (ti_m != 0) begin
            err_sum_m = clip_sum(err_sum_m + err);
            iterm = integral_part(err_sum_m, lt, ti_m);
        end
        if (d_gain_m != 0)
            dterm = scale_q88(last_err_m - err, d_gain_m);
        if (k == KIND_SIGNED || d_gain_m != 0)
            last_err_m = err;

        total = err + iterm + dterm;
        if (total > TERM_CAP)
            total = TERM_CAP;
        if (total < -TERM_CAP)
            total = -TERM_CAP;
        u = scale_q88(total, p_gain_m);

        if (k == KIND_BIASED) begin
            u  = u + BIAS;
            lo = 0;
            hi = BIASED_TOP;
        end
        else begin
            hi = SIGNED_TOP;
            lo = -SIGNED_TOP;
        end
        if (u > hi)
            u = hi;
        if (u < lo)
            u = lo;
        sat = (u == lo) || (u == hi);

        // anti-windup: back this error out of the sum
        if (ti_m != 0 && sat)
            err_sum_m = clip_sum(err_sum_m - err);

        // biased output keeps whole units only; judged saturated before this
        if (k == KIND_BIASED)
            u = (u >>> FRAC_BITS) <<< FRAC_BITS;

        res.drive     = DRIVE_W'(u);
        res.saturated = sat;
        drive_q.push_back(res);
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic int idle_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
    endfunction

    // offer one item, wait for acceptance, then maybe leave a gap
    task automatic send_item(logic [KIND_W-1:0] k, logic signed [IN_W-1:0] sp,
                             logic signed [IN_W-1:0] y, logic [LT_W-1:0] lt);
        in_valid     <= 1'b1;
        kind         <= k;
        setpoint     <= sp;
        measured     <= y;
        loop_time_ms <= lt;
        do @(posedge clk); while (!in_ready);
        regulate_item(k, sp, y, lt);
        if (k != KIND_UNUSED)
            items_sent++;
        if (sender_idles && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat (idle_len()) @(posedge clk);
        end
    endtask

    // stop offering, wait for every result, then let trailing skip items finish
    task automatic drain();
        in_valid <= 1'b0;
        while (drive_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write all three gain registers; only called while the block is idle
    task automatic set_gains(logic [GAIN_W-1:0] p, logic [GAIN_W-1:0] ti,
                             logic [GAIN_W-1:0] d);
        cfg_reg_t          regs [3];
        logic [GAIN_W-1:0] vals [3];
        regs = '{REG_P_GAIN, REG_TI, REG_D_GAIN};
        vals = '{p, ti, d};
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            do @(posedge clk); while (!cfg_ready);
            case (regs[i])
                REG_P_GAIN: p_gain_m = vals[i];
                REG_TI:     ti_m     = vals[i];
                REG_D_GAIN: d_gain_m = vals[i];
                default:    ;
            endcase
        end
        cfg_valid <= 1'b0;
        gain_settings++;
    endtask

    function automatic logic [KIND_W-1:0] pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return KIND_BIASED;
        if (r < 90)
            return KIND_SIGNED;
        if (r < 97)
            return KIND_SKIP;
        return KIND_UNUSED;
    endfunction

    function automatic logic [LT_W-1:0] pick_loop_time();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r < 3)
            return LT_W'($urandom());
        return LT_W'($urandom_range(1, 50));
    endfunction

    // ---------------------------------------------------------------- tests

    // reset gains: zero error, unused kind, both input extremes, skip
    task automatic test_reset_state();
        send_item(KIND_BIASED, '0, '0, '0);
        send_item(KIND_UNUSED, IN_MAX, IN_MIN, '1);
        send_item(KIND_SIGNED, IN_MAX, IN_MIN, '1);
        send_item(KIND_SIGNED, IN_MIN, IN_MAX, '1);
        send_item(KIND_SKIP, '0, '0, '0);
        send_item(KIND_BIASED, 3 * ONE, ONE, 16'd250);
    endtask

    // unity gain, integral and derivative off: edges of both clamp windows
    task automatic test_output_clamps();
        drain();
        set_gains(16'd256, 16'd0, 16'd0);
        send_item(KIND_BIASED, -100 * ONE + ONE / 2, '0, 16'd10);  // fraction only, not clamped
        send_item(KIND_BIASED, -100 * ONE, '0, 16'd10);
        send_item(KIND_BIASED, 100 * ONE, '0, 16'd10);
        send_item(KIND_BIASED, 100 * ONE - 1, '0, 16'd10);          // just under the top
        send_item(KIND_SIGNED, 30 * ONE, '0, 16'd10);
        send_item(KIND_SIGNED, -30 * ONE + 1, '0, 16'd10);
        send_item(KIND_SKIP, ONE, '0, 16'd10);                      // integral off: no effect
    endtask

    // largest and smallest gains: term clamp and rounding toward zero
    task automatic test_gain_extremes();
        drain();
        set_gains('1, 16'd1, '1);
        send_item(KIND_SIGNED, ONE / 4, '0, '1);
        send_item(KIND_SIGNED, -3, '0, 16'd1);
        send_item(KIND_BIASED, 5 * ONE, 7 * ONE, '0);
        send_item(KIND_SKIP, '0, '0, '0);
        drain();
        set_gains(16'd1, '1, 16'd1);
        send_item(KIND_SIGNED, -3, '0, 16'd1);
        send_item(KIND_SIGNED, 5, '0, 16'd7);
        send_item(KIND_BIASED, '0, 1, '1);
    endtask

    // receiver holds off while items keep coming, so the block backs up
    task automatic test_receiver_hold();
        drain();
        set_gains(16'd512, 16'd5120, 16'd256);
        sender_idles = 1'b0;
        hold_request <= 1'b1;
        for (int i = 0; i < 8; i++)
            send_item(i[0] ? KIND_SIGNED : KIND_BIASED, ONE * i, -ONE * i, 16'd20);
        sender_idles = 1'b1;
    endtask

    // phases of random items, each under its own gain setting
    task automatic test_random_phases();
        logic [GAIN_W-1:0]      gp;
        logic [GAIN_W-1:0]      gi;
        logic [GAIN_W-1:0]      gd;
        logic signed [IN_W-1:0] target;
        logic signed [IN_W-1:0] sp;
        logic signed [IN_W-1:0] y;
        logic [KIND_W-1:0]      k;
        int                     n;
        target = '0;
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin gp = P_RESET;    gi = TI_RESET;  gd = D_RESET;   end
                1: begin gp = '0;         gi = 16'd1;     gd = '1;        end
                2: begin gp = '1;         gi = '1;        gd = '0;        end
                3: begin gp = 16'd1;      gi = '0;        gd = 16'd1;     end
                4: begin gp = '1;         gi = 16'd1;     gd = '1;        end
                default:
                begin
                    case ($urandom_range(0, 9))
                        0:       gp = '0;
                        1:       gp = '1;
                        default: gp = GAIN_W'($urandom_range(32, 1024));
                    endcase
                    case ($urandom_range(0, 9))
                        0:       gi = '0;
                        1:       gi = 16'd1;
                        2:       gi = '1;
                        default: gi = GAIN_W'($urandom_range(100, 20000));
                    endcase
                    gd = ($urandom_range(0, 9) < 4) ? '0 : GAIN_W'($urandom_range(1, 2048));
                end
            endcase
            drain();
            set_gains(gp, gi, gd);
            // every fourth phase runs without any gaps
            sender_idles = (ph % 4 != 0);
            sink_idles   = (ph % 4 != 0);

            n = 0;
            while (n < PHASE_ITEMS) begin
                k = pick_kind();
                if ($urandom_range(0, 19) == 0)
                    target = int'($urandom_range(0, 32 * ONE)) - 16 * ONE;
                if ($urandom_range(0, 11) == 0) begin
                    sp = IN_W'($urandom());
                    y  = IN_W'($urandom());
                end
                else begin
                    // measurement tracks the setpoint with some noise
                    sp = target;
                    y  = target + int'($urandom_range(0, 4 * ONE)) - 2 * ONE;
                end
                if (k != KIND_UNUSED)
                    n++;
                send_item(k, sp, y, pick_loop_time());
            end
        end
        sender_idles = 1'b1;
        sink_idles   = 1'b1;
    endtask

    // skip items with the most negative last error push the sum to its ceiling
    task automatic test_error_sum_limit();
        drain();
        set_gains(16'd256, 16'd1, 16'd0);
        sender_idles = 1'b0;
        sink_idles   = 1'b0;
        send_item(KIND_SIGNED, IN_MIN, IN_MAX, '0);
        while (err_sum_m < SUM_HI) begin
            send_item(KIND_SKIP, '0, '0, '0);
            skip_fill++;
        end
        send_item(KIND_SKIP, '0, '0, '0);
        send_item(KIND_SIGNED, IN_MAX, IN_MIN, '1);
        send_item(KIND_SIGNED, '0, '0, '1);
        send_item(KIND_BIASED, -ONE, '0, 16'd1);
    endtask

    // ---------------------------------------------------------------- result side

    // receiver: random stalls, plus one long hold-off on request
    initial begin : result_sink
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request <= 1'b0;
                out_ready    <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (sink_idles && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat (idle_len()) @(posedge clk);
                out_ready <= 1'b1;
            end
            else begin
                out_ready <= 1'b1;
            end
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge clk) begin : check_results
        drive_result_t want;
        if (out_valid && out_ready) begin
            if (drive_q.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: unexpected result, drive %0d saturated %0b",
                             $time, drive, saturated);
            end
            else begin
                want = drive_q.pop_front();
                results_seen++;
                if (want.saturated)
                    clamp_hits++;
                if (want.drive !== drive || want.saturated !== saturated) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        if (want.drive !== drive)
                            $display("%0t: drive mismatch, expected %0d, got %0d",
                                     $time, want.drive, drive);
                        if (want.saturated !== saturated)
                            $display("%0t: saturated mismatch, expected %0b, got %0b",
                                     $time, want.saturated, saturated);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("pid_regulator_antiwindup test failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_output_clamps();
        test_gain_extremes();
        test_receiver_hold();
        test_random_phases();
        test_error_sum_limit();
        drain();

        $display("Sent %0d items under %0d gain settings; checked %0d results, %0d of them clamped.",
                 items_sent, gain_settings, results_seen, clamp_hits);
        $display("Error sum driven to its ceiling by %0d skip items; receiver held off %0d cycles.",
                 skip_fill, HOLD_CYCLES);
        if (fail_count == 0)
            $display("pid_regulator_antiwindup test passed");
        else
            $display("pid_regulator_antiwindup test failed");
        $finish;
    end

endmodule
